@@ hdl/upa_pkg.sv @@
package upa_pkg;

    // Longest series; the sample that follows a full series flags overflow.
    localparam int MAX_FRAMES  = 256;

    localparam int VAL_W       = 20;                        // Q16.4 intensity
    localparam int FRAME_W     = $clog2(MAX_FRAMES);        // frame index
    localparam int CNT_W       = $clog2(MAX_FRAMES + 1);    // frames taken
    localparam int OUT_FRAME_W = 8;                         // reported index
    localparam int UP_W        = 21;                        // signed Q.4
    localparam int STAT_W      = 3;
    localparam int IN_DATA_W   = 24;
    localparam int OUT_DATA_W  = 80;

    // Restoring divider: one quotient bit per step.
    localparam int DIV_STEPS   = VAL_W;
    localparam int STEP_W      = $clog2(DIV_STEPS);

    localparam logic [VAL_W-1:0] THR_RESET = VAL_W'(160);   // 10.0

    typedef enum logic [STAT_W-1:0] {
        STAT_OK       = 3'd0,
        STAT_NO_PEAK  = 3'd1,
        STAT_NO_ARRV  = 3'd2,
        STAT_SAME_FRM = 3'd3,
        STAT_TOO_LONG = 3'd4
    } status_t;

    typedef struct packed {
        logic take;       // sample beat accepted
        logic div_load;   // load divider operands
        logic div_step;   // one divider iteration
        logic out_load;   // result to output register, clear series
    } upa_cmd_t;

    typedef struct packed {
        logic out_free;   // output register empty or draining this cycle
    } upa_sts_t;

endpackage

@@ hdl/upa_ctrl.sv @@
module upa_ctrl
    import upa_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    input  logic     s_tlast,
    output logic     s_tready,
    output upa_cmd_t cmd,
    input  upa_sts_t sts
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SETUP = 4'b0010,
        ST_DIV   = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    logic   [STEP_W-1:0] step_reg,  step_next;
    logic                take;

    assign s_tready = (state_reg == ST_IDLE);
    assign take     = s_tvalid && s_tready;

    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        cmd.take     = take;
        cmd.div_load = 1'b0;
        cmd.div_step = 1'b0;
        cmd.out_load = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (take && s_tlast)
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                cmd.div_load = 1'b1;
                step_next    = STEP_W'(DIV_STEPS - 1);
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg - STEP_W'(1);
                if (step_reg == '0)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

@@ hdl/upa_dp.sv @@
module upa_dp
    import upa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  upa_cmd_t              cmd,
    output upa_sts_t              sts,
    input  logic [VAL_W-1:0]      sample,
    input  logic                  cfg_we,
    input  logic [VAL_W-1:0]      cfg_data,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata
);

    // series tracking
    logic [VAL_W-1:0]   thr_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [VAL_W-1:0]   prev_reg;
    logic [VAL_W-1:0]   best_val_reg;
    logic [FRAME_W-1:0] best_frm_reg;
    logic               best_fnd_reg;
    logic               ons_fnd_reg;
    logic [FRAME_W-1:0] ons_frm_reg;
    logic [VAL_W-1:0]   ons_val_reg;
    logic               ovf_reg;

    // divider
    logic [VAL_W-1:0]   dvd_reg;      // dividend, becomes quotient
    logic [FRAME_W-1:0] den_reg;
    logic [FRAME_W-1:0] rem_reg;
    logic               neg_reg;

    // output register
    logic                  out_vld_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    logic [FRAME_W-1:0] idx;
    logic [VAL_W:0]     rise_lim;
    logic               rise_hit;
    logic               full;

    logic signed [VAL_W:0]   num;
    logic signed [FRAME_W:0] den;
    logic [VAL_W:0]          num_mag;
    logic [FRAME_W:0]        den_mag;

    logic [FRAME_W:0]   shifted;
    logic               ge;
    logic [FRAME_W:0]   shifted_sub;

    logic [UP_W-1:0]    quo_ext;
    logic [UP_W-1:0]    up_val;

    logic [FRAME_W+OUT_FRAME_W-1:0] pf_ext;
    logic [FRAME_W+OUT_FRAME_W-1:0] af_ext;

    status_t               stat;
    logic [OUT_FRAME_W-1:0] pf_o;
    logic [VAL_W-1:0]       pv_o;
    logic [OUT_FRAME_W-1:0] af_o;
    logic [VAL_W-1:0]       av_o;
    logic [UP_W-1:0]        up_o;

    assign idx      = cnt_reg[FRAME_W-1:0];
    assign full     = (cnt_reg >= CNT_W'(MAX_FRAMES));
    assign rise_lim = {1'b0, prev_reg} + {1'b0, thr_reg};
    assign rise_hit = ({1'b0, sample} > rise_lim);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_RESET;
        end
        else if (cfg_we)
        begin
            thr_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            prev_reg     <= '0;
            best_val_reg <= '0;
            best_frm_reg <= '0;
            best_fnd_reg <= 1'b0;
            ons_fnd_reg  <= 1'b0;
            ons_frm_reg  <= '0;
            ons_val_reg  <= '0;
            ovf_reg      <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            cnt_reg      <= '0;
            prev_reg     <= '0;
            best_val_reg <= '0;
            best_frm_reg <= '0;
            best_fnd_reg <= 1'b0;
            ons_fnd_reg  <= 1'b0;
            ons_frm_reg  <= '0;
            ons_val_reg  <= '0;
            ovf_reg      <= 1'b0;
        end
        else if (cmd.take)
        begin
            if (full)
            begin
                ovf_reg <= 1'b1;
            end
            else
            begin
                if ((cnt_reg != '0) && !ons_fnd_reg && rise_hit)
                begin
                    ons_fnd_reg <= 1'b1;
                    ons_frm_reg <= idx - FRAME_W'(1);
                    ons_val_reg <= prev_reg;
                end
                if (sample > best_val_reg)
                begin
                    best_val_reg <= sample;
                    best_frm_reg <= idx;
                    best_fnd_reg <= 1'b1;
                end
                prev_reg <= sample;
                cnt_reg  <= cnt_reg + CNT_W'(1);
            end
        end
    end

    // signed operands, divided as magnitudes
    assign num     = $signed({1'b0, best_val_reg}) - $signed({1'b0, ons_val_reg});
    assign den     = $signed({1'b0, best_frm_reg}) - $signed({1'b0, ons_frm_reg});
    assign num_mag = num[VAL_W]   ? (VAL_W+1)'(-num)   : num;
    assign den_mag = den[FRAME_W] ? (FRAME_W+1)'(-den) : den;

    assign shifted     = {rem_reg, dvd_reg[VAL_W-1]};
    assign ge          = (shifted >= {1'b0, den_reg});
    assign shifted_sub = shifted - {1'b0, den_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
        begin
            dvd_reg <= num_mag[VAL_W-1:0];
            den_reg <= den_mag[FRAME_W-1:0];
            rem_reg <= '0;
            neg_reg <= num[VAL_W] ^ den[FRAME_W];
        end
        else if (cmd.div_step)
        begin
            rem_reg <= ge ? shifted_sub[FRAME_W-1:0] : shifted[FRAME_W-1:0];
            dvd_reg <= {dvd_reg[VAL_W-2:0], ge};
        end
    end

    assign quo_ext = {1'b0, dvd_reg};
    assign up_val  = neg_reg ? (-quo_ext) : quo_ext;

    assign pf_ext = (FRAME_W+OUT_FRAME_W)'(best_frm_reg);
    assign af_ext = (FRAME_W+OUT_FRAME_W)'(ons_frm_reg);

    // status priority: too long, no peak, no arrival, same frame
    always_comb
    begin
        stat = STAT_OK;
        pf_o = '0;
        pv_o = '0;
        af_o = '0;
        av_o = '0;
        up_o = '0;
        priority if (ovf_reg)
        begin
            stat = STAT_TOO_LONG;
        end
        else if (!best_fnd_reg)
        begin
            stat = STAT_NO_PEAK;
        end
        else
        begin
            pf_o = pf_ext[OUT_FRAME_W-1:0];
            pv_o = best_val_reg;
            if (!ons_fnd_reg)
            begin
                stat = STAT_NO_ARRV;
            end
            else
            begin
                af_o = af_ext[OUT_FRAME_W-1:0];
                av_o = ons_val_reg;
                if (best_frm_reg == ons_frm_reg)
                begin
                    stat = STAT_SAME_FRM;
                end
                else
                begin
                    up_o = up_val;
                end
            end
        end
    end

    assign sts.out_free = !out_vld_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_data_reg <= {stat, up_o, av_o, af_o, pv_o, pf_o};
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

endmodule

@@ hdl/perfusion_upslope_analyzer.sv @@
// Channel  | Dir | Handshake            | Payload
// ---------+-----+----------------------+------------------------------------------
// s_*      | in  | s_tvalid / s_tready  | s_tdata: sample; s_tlast: last_sample
// m_*      | out | m_tvalid / m_tready  | m_tdata: peak/arrival/upslope/status
// cfg_*    | in  | cfg_valid / cfg_ready| cfg_data: arrival_threshold
//
// Non-final sample beats may arrive back to back. After the final beat of a
// series the block sets up the operands, runs the restoring divider one
// quotient bit per step, then loads the output register. s_tready is low from
// the final beat until that load, and longer only while the output register
// still holds an unread result. Once loaded, a waiting result does not block
// the next series.
// Reset (rst_n, async, active low) empties the output, clears the series and
// sets arrival_threshold to 10.0. cfg_ready is always high.
module perfusion_upslope_analyzer
    import upa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // [19:0] sample, [23:20] zero
    input  logic                  s_tlast,   // last_sample

    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [7:0] peak_frame, [27:8] peak_value, [35:28] arrival_frame,
    // [55:36] arrival_value, [76:56] upslope, [79:77] status
    output logic [OUT_DATA_W-1:0] m_tdata,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [VAL_W-1:0]      cfg_data   // arrival_threshold, Q16.4
);

    upa_cmd_t cmd;
    upa_sts_t sts;

    assign cfg_ready = 1'b1;

    // sequencer: per-sample update, divide, result handoff
    upa_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    // tracking registers, divider and output register
    upa_dp u_dp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .sample   (s_tdata[VAL_W-1:0]),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
